// File: src/shape_table_pixel_coverage_core_macros.svh
// ----------------------------------------------------------------------------
// Shape table coverage core - assertion macros
// Shared property wrappers used by the core's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SHAPE_TABLE_PIXEL_COVERAGE_CORE_MACROS_SVH
`define SHAPE_TABLE_PIXEL_COVERAGE_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define STPC_ASSERT_IMPL(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("stpc: same-cycle check failed");

// next-cycle implication, disabled in reset
`define STPC_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("stpc: next-cycle check failed");

`endif

// File: src/stpc_pkg.sv
// ----------------------------------------------------------------------------
// Shape table coverage package
// Field widths, command/status/type codes, table entry layout and states.
// ----------------------------------------------------------------------------
package stpc_pkg;

    // field widths
    localparam int CMD_W    = 2;
    localparam int TYPE_W   = 3;
    localparam int NUM_W    = 6;
    localparam int COORD_W  = 10;
    localparam int PIX_X_W  = 6;
    localparam int PIX_Y_W  = 5;
    localparam int STATUS_W = 2;

    // commands
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_NUM = 2'd2;

    // shape types; anything else is inert
    localparam logic [TYPE_W-1:0] KIND_RECT   = 3'd1;
    localparam logic [TYPE_W-1:0] KIND_LINE   = 3'd2;
    localparam logic [TYPE_W-1:0] KIND_TRI    = 3'd3;
    localparam logic [TYPE_W-1:0] KIND_CIRCLE = 3'd4;

    // one table word: active flag, type and four coordinates
    typedef struct packed {
        logic                      active;
        logic [TYPE_W-1:0]         kind;
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
        logic signed [COORD_W-1:0] c;
        logic signed [COORD_W-1:0] d;
    } entry_t;

    // coverage pipe result
    typedef struct packed {
        logic valid;
        logic hit;
    } cover_res_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RMW,
        S_WALK,
        S_RESULT
    } state_t;

endpackage

// File: src/stpc_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module stpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/stpc_cover.sv
// ----------------------------------------------------------------------------
// Shape coverage pipe
// Two stages: compares and squares registered, then circle sum and type select.
// ----------------------------------------------------------------------------
module stpc_cover (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  stpc_pkg::entry_t                     entry,
    input  logic [stpc_pkg::PIX_X_W-1:0]         pixel_x,
    input  logic [stpc_pkg::PIX_Y_W-1:0]         pixel_y,
    output stpc_pkg::cover_res_t                 res
);

    import stpc_pkg::*;

    // working widths: coordinate plus sign/carry headroom, squares, sum
    localparam int WW = COORD_W + 2;
    localparam int PW = 2 * WW;
    localparam int SW = PW + 1;

    logic signed [WW-1:0] a_w, b_w, c_w, d_w, px_w, py_w;
    logic signed [WW-1:0] a_plus_c, b_plus_d, dx, dy, adx;
    logic                 x_span, y_span;

    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_active_reg, s1_active_next;
    logic [TYPE_W-1:0]    s1_kind_reg, s1_kind_next;
    logic                 s1_rect_reg, s1_rect_next;
    logic                 s1_line_reg, s1_line_next;
    logic                 s1_tri_reg, s1_tri_next;
    logic signed [PW-1:0] s1_dx2_reg, s1_dx2_next;
    logic signed [PW-1:0] s1_dy2_reg, s1_dy2_next;
    logic signed [PW-1:0] s1_r2_reg, s1_r2_next;

    logic signed [SW-1:0] dist2;
    logic                 circ_hit;
    logic                 kind_hit;

    // operand extension
    assign a_w  = {{(WW-COORD_W){entry.a[COORD_W-1]}}, entry.a};
    assign b_w  = {{(WW-COORD_W){entry.b[COORD_W-1]}}, entry.b};
    assign c_w  = {{(WW-COORD_W){entry.c[COORD_W-1]}}, entry.c};
    assign d_w  = {{(WW-COORD_W){entry.d[COORD_W-1]}}, entry.d};
    assign px_w = {{(WW-PIX_X_W){1'b0}}, pixel_x};
    assign py_w = {{(WW-PIX_Y_W){1'b0}}, pixel_y};

    // stage 1: per-type compares and the three squares
    always_comb
    begin
        a_plus_c = a_w + c_w;
        b_plus_d = b_w + d_w;
        dx       = px_w - a_w;
        dy       = py_w - b_w;
        adx      = dx[WW-1] ? -dx : dx;
        x_span   = ((px_w >= a_w) && (px_w <= c_w)) || ((px_w >= c_w) && (px_w <= a_w));
        y_span   = ((py_w >= b_w) && (py_w <= d_w)) || ((py_w >= d_w) && (py_w <= b_w));

        s1_valid_next  = in_valid;
        s1_active_next = entry.active;
        s1_kind_next   = entry.kind;
        s1_rect_next   = (px_w >= a_w) && (px_w < a_plus_c)
                      && (py_w >= b_w) && (py_w < b_plus_d);
        // horizontal first, then vertical, else nothing
        priority if (b_w == d_w)
        begin
            s1_line_next = (py_w == b_w) && x_span;
        end
        else if (a_w == c_w)
        begin
            s1_line_next = (px_w == a_w) && y_span;
        end
        else
        begin
            s1_line_next = 1'b0;
        end
        // dy is the row offset below the apex
        s1_tri_next = !dy[WW-1] && (dy < c_w) && (adx <= dy);
        s1_dx2_next = dx * dx;
        s1_dy2_next = dy * dy;
        s1_r2_next  = c_w * c_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_active_reg <= s1_active_next;
        s1_kind_reg   <= s1_kind_next;
        s1_rect_reg   <= s1_rect_next;
        s1_line_reg   <= s1_line_next;
        s1_tri_reg    <= s1_tri_next;
        s1_dx2_reg    <= s1_dx2_next;
        s1_dy2_reg    <= s1_dy2_next;
        s1_r2_reg     <= s1_r2_next;
    end

    // stage 2: circle distance test and type select
    assign dist2    = SW'(s1_dx2_reg) + SW'(s1_dy2_reg);
    assign circ_hit = (dist2 <= SW'(s1_r2_reg));

    always_comb
    begin
        unique case (s1_kind_reg)
            KIND_RECT:   kind_hit = s1_rect_reg;
            KIND_LINE:   kind_hit = s1_line_reg;
            KIND_TRI:    kind_hit = s1_tri_reg;
            KIND_CIRCLE: kind_hit = circ_hit;
            default:     kind_hit = 1'b0;
        endcase
    end

    assign res.valid = s1_valid_reg;
    assign res.hit   = s1_active_reg && kind_hit;

endmodule

// File: src/shape_table_pixel_coverage_core.sv
// ----------------------------------------------------------------------------
// Shape table pixel coverage core
// Shape table in one RAM; add/delete/modify commands and per-pixel queries.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------------
//   in      | in_valid/in_ready  | cmd shape_type shape_number coord_a..d px py
//   out     | out_valid/out_ready| status covered assigned_number
//
// Add writes its entry on acceptance; delete and modify read the entry, then
// write it back. A query has the single RAM read port walk one entry a cycle
// into a two-stage coverage pipe. One command at a time.
// Reset clears the count and control only; entries at or above the count
// are never read, so the RAM needs no clearing pass.
// A finished result waits in the output register; the next command is taken
// meanwhile and stalls only when its own result meets a full register.
// ----------------------------------------------------------------------------
`include "shape_table_pixel_coverage_core_macros.svh"

module shape_table_pixel_coverage_core #(
    parameter int TABLE_DEPTH = 32,
    parameter int CANVAS_COLS = 50,
    parameter int CANVAS_ROWS = 25
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [stpc_pkg::CMD_W-1:0]           cmd,
    input  logic [stpc_pkg::TYPE_W-1:0]          shape_type,
    input  logic [stpc_pkg::NUM_W-1:0]           shape_number,
    input  logic signed [stpc_pkg::COORD_W-1:0]  coord_a,
    input  logic signed [stpc_pkg::COORD_W-1:0]  coord_b,
    input  logic signed [stpc_pkg::COORD_W-1:0]  coord_c,
    input  logic signed [stpc_pkg::COORD_W-1:0]  coord_d,
    input  logic [stpc_pkg::PIX_X_W-1:0]         pixel_x,
    input  logic [stpc_pkg::PIX_Y_W-1:0]         pixel_y,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [stpc_pkg::STATUS_W-1:0]        status,
    output logic                                 covered,
    output logic [stpc_pkg::NUM_W-1:0]           assigned_number
);

    import stpc_pkg::*;

    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int UW  = $clog2(TABLE_DEPTH + 1);
    localparam int CW  = (UW > NUM_W) ? UW : NUM_W;
    localparam int XCW = ($clog2(CANVAS_COLS + 1) > PIX_X_W) ? $clog2(CANVAS_COLS + 1) : PIX_X_W;
    localparam int YCW = ($clog2(CANVAS_ROWS + 1) > PIX_Y_W) ? $clog2(CANVAS_ROWS + 1) : PIX_Y_W;
    localparam int EW  = $bits(entry_t);

    // control state
    state_t                state_reg, state_next;
    logic [UW-1:0]         used_reg, used_next;
    logic [AW-1:0]         walk_idx_reg, walk_idx_next;
    logic                  issue_done_reg, issue_done_next;
    logic                  rd_pending_reg, rd_pending_next;
    logic                  out_valid_reg, out_valid_next;

    // command held for the walk or write-back
    logic [CMD_W-1:0]          cmd_reg, cmd_next;
    logic [AW-1:0]             addr_reg, addr_next;
    logic signed [COORD_W-1:0] ca_reg, ca_next;
    logic signed [COORD_W-1:0] cb_reg, cb_next;
    logic signed [COORD_W-1:0] cc_reg, cc_next;
    logic signed [COORD_W-1:0] cd_reg, cd_next;
    logic [PIX_X_W-1:0]        px_reg, px_next;
    logic [PIX_Y_W-1:0]        py_reg, py_next;

    // result being built and output register
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  res_covered_reg, res_covered_next;
    logic [NUM_W-1:0]      res_assigned_reg, res_assigned_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic                  out_covered_reg, out_covered_next;
    logic [NUM_W-1:0]      out_assigned_reg, out_assigned_next;

    // RAM port
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    entry_t                ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [EW-1:0]         ram_rdata;
    entry_t                rd_entry;

    cover_res_t            cres;

    // decode
    logic                  accept;
    logic                  table_full;
    logic                  add_ok;
    logic [CW-1:0]         num_ext;
    logic                  num_ok;
    logic [AW-1:0]         num_addr;
    logic                  on_canvas;
    logic                  last_issue;
    logic                  out_free;
    logic                  walk_done;
    entry_t                new_entry;

    assign accept     = in_valid && in_ready;
    assign table_full = (used_reg == UW'(TABLE_DEPTH));
    assign add_ok     = accept && (cmd == CMD_ADD) && !table_full;
    assign num_ext    = CW'(shape_number);
    assign num_ok     = (num_ext != '0) && (num_ext <= CW'(used_reg));
    assign num_addr   = AW'(num_ext - CW'(1));
    assign on_canvas  = (XCW'(pixel_x) < XCW'(CANVAS_COLS))
                     && (YCW'(pixel_y) < YCW'(CANVAS_ROWS));
    assign last_issue = (walk_idx_reg == AW'(used_reg - UW'(1)));
    assign out_free   = !out_valid_reg || out_ready;
    assign walk_done  = issue_done_reg && !rd_pending_reg && !cres.valid;
    assign rd_entry   = entry_t'(ram_rdata);

    always_comb
    begin
        new_entry.active = 1'b1;
        new_entry.kind   = shape_type;
        new_entry.a      = coord_a;
        new_entry.b      = coord_b;
        new_entry.c      = coord_c;
        new_entry.d      = coord_d;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (cmd == CMD_ADD)
                    begin
                        state_next = S_RESULT;
                    end
                    else if (cmd == CMD_QUERY)
                    begin
                        state_next = (on_canvas && (used_reg != '0)) ? S_WALK : S_RESULT;
                    end
                    else
                    begin
                        state_next = num_ok ? S_RMW : S_RESULT;
                    end
                end
            end
            S_RMW:
            begin
                state_next = S_RESULT;
            end
            S_WALK:
            begin
                if (walk_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // outputs of the sequencer: handshake and RAM control
    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = new_entry;
        ram_re    = 1'b0;
        ram_raddr = walk_idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (add_ok)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(used_reg);
                end
                if (accept && ((cmd == CMD_DELETE) || (cmd == CMD_MODIFY)) && num_ok)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = num_addr;
                end
            end
            S_RMW:
            begin
                // write back: delete drops active, modify writes the new coordinates
                ram_we    = 1'b1;
                ram_wdata = rd_entry;
                if (cmd_reg == CMD_DELETE)
                begin
                    ram_wdata.active = 1'b0;
                end
                else
                begin
                    ram_wdata.a = ca_reg;
                    ram_wdata.b = cb_reg;
                    ram_wdata.c = cc_reg;
                    ram_wdata.d = cd_reg;
                end
            end
            S_WALK:
            begin
                ram_re = !issue_done_reg;
            end
            S_RESULT:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        used_next         = used_reg;
        walk_idx_next     = walk_idx_reg;
        issue_done_next   = issue_done_reg;
        rd_pending_next   = (state_reg == S_WALK) && !issue_done_reg;
        cmd_next          = cmd_reg;
        addr_next         = addr_reg;
        ca_next           = ca_reg;
        cb_next           = cb_reg;
        cc_next           = cc_reg;
        cd_next           = cd_reg;
        px_next           = px_reg;
        py_next           = py_reg;
        res_status_next   = res_status_reg;
        res_covered_next  = res_covered_reg;
        res_assigned_next = res_assigned_reg;
        out_valid_next    = out_valid_reg;
        out_status_next   = out_status_reg;
        out_covered_next  = out_covered_reg;
        out_assigned_next = out_assigned_reg;

        // capture the command
        if (accept)
        begin
            cmd_next          = cmd;
            addr_next         = num_addr;
            ca_next           = coord_a;
            cb_next           = coord_b;
            cc_next           = coord_c;
            cd_next           = coord_d;
            px_next           = pixel_x;
            py_next           = pixel_y;
            walk_idx_next     = '0;
            issue_done_next   = 1'b0;
            res_status_next   = ST_OK;
            res_covered_next  = 1'b0;
            res_assigned_next = '0;
            if (cmd == CMD_ADD)
            begin
                if (table_full)
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    used_next         = used_reg + UW'(1);
                    res_assigned_next = NUM_W'(CW'(used_reg) + CW'(1));
                end
            end
            else if ((cmd != CMD_QUERY) && !num_ok)
            begin
                res_status_next = ST_BAD_NUM;
            end
        end

        // entry walk and hit accumulation
        if (state_reg == S_WALK)
        begin
            if (!issue_done_reg)
            begin
                if (last_issue)
                begin
                    issue_done_next = 1'b1;
                end
                else
                begin
                    walk_idx_next = walk_idx_reg + AW'(1);
                end
            end
            res_covered_next = res_covered_reg || (cres.valid && cres.hit);
        end

        // output register
        if ((state_reg == S_RESULT) && out_free)
        begin
            out_valid_next    = 1'b1;
            out_status_next   = res_status_reg;
            out_covered_next  = res_covered_reg;
            out_assigned_next = res_assigned_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            walk_idx_reg   <= '0;
            issue_done_reg <= 1'b1;
            rd_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            walk_idx_reg   <= walk_idx_next;
            issue_done_reg <= issue_done_next;
            rd_pending_reg <= rd_pending_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        addr_reg         <= addr_next;
        ca_reg           <= ca_next;
        cb_reg           <= cb_next;
        cc_reg           <= cc_next;
        cd_reg           <= cd_next;
        px_reg           <= px_next;
        py_reg           <= py_next;
        res_status_reg   <= res_status_next;
        res_covered_reg  <= res_covered_next;
        res_assigned_reg <= res_assigned_next;
        out_status_reg   <= out_status_next;
        out_covered_reg  <= out_covered_next;
        out_assigned_reg <= out_assigned_next;
    end

    // shape table
    stpc_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // coverage pipe fed by the walk reads
    stpc_cover u_cover (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rd_pending_reg),
        .entry    (rd_entry),
        .pixel_x  (px_reg),
        .pixel_y  (py_reg),
        .res      (cres)
    );

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign covered         = out_covered_reg;
    assign assigned_number = out_assigned_reg;

    // checks
    `STPC_ASSERT_IMPL(a_used_bound, clk, rst_n, 1'b1, used_reg <= UW'(TABLE_DEPTH))
    `STPC_ASSERT_IMPL(a_one_port_op, clk, rst_n, ram_we, !ram_re)
    `STPC_ASSERT_IMPL(a_walk_no_write, clk, rst_n, state_reg == S_WALK, !ram_we)
    `STPC_ASSERT_NEXT(a_add_counts, clk, rst_n, add_ok, used_reg == $past(used_reg) + UW'(1))

endmodule
